FILE: src/tcw_pkg.sv
// Shared constants, field widths and command codes of the text console writer.
// No dependencies; used by the channel interfaces and by text_console_writer.
package tcw_pkg;

  localparam int COLS   = 80;
  localparam int ROWS   = 25;
  localparam int CELLS  = COLS * ROWS;
  localparam int COL_W  = $clog2(COLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELLS);

  // Field widths of the command and response channels
  localparam int OPCODE_W  = 3;
  localparam int BYTE_W    = 8;
  localparam int CUR_COL_W = 7;
  localparam int CUR_ROW_W = 5;
  // Target row plus the rows that an oversized column spills into
  localparam int TROW_W    = BYTE_W + 1;

  localparam logic [BYTE_W-1:0] THEME_DEFAULT = 8'h07;
  localparam logic [BYTE_W-1:0] COLOR_MAX     = 8'd15;
  localparam logic [BYTE_W-1:0] CHAR_NEWLINE  = 8'd10;
  localparam logic [BYTE_W-1:0] CHAR_PRINT_LO = 8'd32;
  localparam logic [BYTE_W-1:0] CHAR_PRINT_HI = 8'd126;
  localparam logic [BYTE_W-1:0] CHAR_SUBST    = 8'd63;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUT       = 3'd0,
    OP_SET_CHAR  = 3'd1,
    OP_SET_THEME = 3'd2,
    OP_SET_ALL   = 3'd3,
    OP_CLEAR     = 3'd4,
    OP_SET_CUR   = 3'd5,
    OP_READ      = 3'd6
  } op_t;

  typedef enum logic [7:0] {
    S_INIT   = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_DIV    = 8'b0000_0100,
    S_EXEC   = 8'b0000_1000,
    S_READ   = 8'b0001_0000,
    S_FILL   = 8'b0010_0000,
    S_SCROLL = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

endpackage

FILE: src/tcw_cmd_if.sv
// Command channel of the text console writer: valid/ready plus command fields.
// Depends on tcw_pkg for the field widths.
interface tcw_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [tcw_pkg::OPCODE_W-1:0]  opcode;
  logic [tcw_pkg::BYTE_W-1:0]    char_code;
  logic                          use_theme;
  logic [tcw_pkg::BYTE_W-1:0]    fg_color;
  logic [tcw_pkg::BYTE_W-1:0]    bg_color;
  logic [tcw_pkg::BYTE_W-1:0]    col;
  logic [tcw_pkg::BYTE_W-1:0]    row;

  modport source (
    output valid, opcode, char_code, use_theme, fg_color, bg_color, col, row,
    input  ready
  );
  modport sink (
    input  valid, opcode, char_code, use_theme, fg_color, bg_color, col, row,
    output ready
  );
endinterface

FILE: src/tcw_rsp_if.sv
// Response channel of the text console writer: valid/ready plus result fields.
// Depends on tcw_pkg for the field widths.
interface tcw_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [tcw_pkg::CUR_COL_W-1:0]  cursor_col;
  logic [tcw_pkg::CUR_ROW_W-1:0]  cursor_row;
  logic [tcw_pkg::BYTE_W-1:0]     cell_char;
  logic [tcw_pkg::BYTE_W-1:0]     cell_attr;

  modport source (
    output valid, cursor_col, cursor_row, cell_char, cell_attr,
    input  ready
  );
  modport sink (
    input  valid, cursor_col, cursor_row, cell_char, cell_attr,
    output ready
  );
endinterface

FILE: src/text_console_writer.sv
// Path to response valid: put and unused opcode pass S_EXEC, S_DONE; cell write,
// set cursor and cell read first fold the column in S_DIV; an in-range read adds S_READ.
// Set all themes and clear sweep all cells in S_FILL; a scrolling put copies rows up in
// S_SCROLL and fills the last row; one write port sweeps both memories one cell a cycle.
// One command at a time: cmd.ready rises with response valid; a waiting response holds it.
// Reset: synchronous; a clearing pass over all CELLS cells follows, with cmd.ready low.
module text_console_writer (
  input  logic           clk,
  input  logic           rst,
  tcw_cmd_if.sink        cmd,
  tcw_rsp_if.source      rsp
);

  tcw_pkg::state_t state, state_next;

  logic [tcw_pkg::ADDR_W-1:0]   idx;
  logic [tcw_pkg::ROW_W-1:0]    cur_row;
  logic [tcw_pkg::COL_W-1:0]    cur_col;
  logic [tcw_pkg::BYTE_W-1:0]   global_theme;

  logic [tcw_pkg::OPCODE_W-1:0] op_r;
  logic [tcw_pkg::BYTE_W-1:0]   code_r;
  logic                         use_theme_r;
  logic [tcw_pkg::BYTE_W-1:0]   theme_r;
  logic [tcw_pkg::TROW_W-1:0]   t_row;
  logic [tcw_pkg::BYTE_W-1:0]   t_col;
  logic                         fill_char;
  logic                         fill_attr;
  logic [tcw_pkg::BYTE_W-1:0]   res_char;
  logic [tcw_pkg::BYTE_W-1:0]   res_attr;

  logic                           rsp_valid;
  logic [tcw_pkg::CUR_COL_W-1:0]  rsp_col;
  logic [tcw_pkg::CUR_ROW_W-1:0]  rsp_row;
  logic [tcw_pkg::BYTE_W-1:0]     rsp_char;
  logic [tcw_pkg::BYTE_W-1:0]     rsp_attr;

  logic [tcw_pkg::BYTE_W-1:0] char_mem [tcw_pkg::CELLS];
  logic [tcw_pkg::BYTE_W-1:0] attr_mem [tcw_pkg::CELLS];
  logic [tcw_pkg::BYTE_W-1:0] char_q;
  logic [tcw_pkg::BYTE_W-1:0] attr_q;
  logic [tcw_pkg::ADDR_W-1:0] wr_addr;
  logic [tcw_pkg::ADDR_W-1:0] rd_addr;
  logic                       char_we;
  logic                       attr_we;
  logic                       rd_en;
  logic [tcw_pkg::BYTE_W-1:0] char_wd;
  logic [tcw_pkg::BYTE_W-1:0] attr_wd;

  logic [tcw_pkg::ADDR_W-1:0] cell_addr;
  logic                       in_range;
  logic                       is_newline;
  logic [tcw_pkg::BYTE_W-1:0] put_code;
  logic                       put_wrap;
  logic                       put_scroll;
  logic [tcw_pkg::BYTE_W-1:0] cmd_theme;
  logic                       rsp_free;

  localparam logic [tcw_pkg::ADDR_W-1:0] LAST_CELL  = tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1);
  localparam logic [tcw_pkg::ADDR_W-1:0] SCROLL_END =
    tcw_pkg::ADDR_W'(tcw_pkg::CELLS - tcw_pkg::COLS);
  localparam logic [tcw_pkg::COL_W-1:0]  LAST_COL   = tcw_pkg::COL_W'(tcw_pkg::COLS - 1);
  localparam logic [tcw_pkg::ROW_W-1:0]  LAST_ROW   = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
  localparam logic [tcw_pkg::BYTE_W-1:0] COLS_B     = tcw_pkg::BYTE_W'(tcw_pkg::COLS);

  assign cell_addr = tcw_pkg::ADDR_W'(t_row[tcw_pkg::ROW_W-1:0])
                   * tcw_pkg::ADDR_W'(tcw_pkg::COLS) + tcw_pkg::ADDR_W'(t_col);
  assign in_range   = t_row < tcw_pkg::TROW_W'(tcw_pkg::ROWS);
  assign is_newline = code_r == tcw_pkg::CHAR_NEWLINE;
  assign put_code   = (code_r < tcw_pkg::CHAR_PRINT_LO || code_r > tcw_pkg::CHAR_PRINT_HI)
                    ? tcw_pkg::CHAR_SUBST : code_r;
  assign put_wrap   = is_newline || cur_col == LAST_COL;
  assign put_scroll = put_wrap && cur_row == LAST_ROW;
  assign cmd_theme  = (cmd.fg_color <= tcw_pkg::COLOR_MAX && cmd.bg_color <= tcw_pkg::COLOR_MAX)
                    ? {cmd.bg_color[3:0], cmd.fg_color[3:0]} : tcw_pkg::THEME_DEFAULT;
  assign rsp_free   = !rsp_valid || rsp.ready;

  assign cmd.ready      = state == tcw_pkg::S_IDLE;
  assign rsp.valid      = rsp_valid;
  assign rsp.cursor_col = rsp_col;
  assign rsp.cursor_row = rsp_row;
  assign rsp.cell_char  = rsp_char;
  assign rsp.cell_attr  = rsp_attr;

  // Memory port control and sequencer
  always_comb begin
    state_next = state;
    wr_addr    = idx;
    rd_addr    = cell_addr;
    char_we    = 1'b0;
    attr_we    = 1'b0;
    rd_en      = 1'b0;
    char_wd    = '0;
    attr_wd    = global_theme;
    unique case (state)
      tcw_pkg::S_INIT: begin
        char_we = 1'b1;
        attr_we = 1'b1;
        attr_wd = tcw_pkg::THEME_DEFAULT;
        if (idx == LAST_CELL) state_next = tcw_pkg::S_IDLE;
      end
      tcw_pkg::S_IDLE: begin
        if (cmd.valid) begin
          if (cmd.opcode == tcw_pkg::OP_SET_CHAR || cmd.opcode == tcw_pkg::OP_SET_THEME ||
              cmd.opcode == tcw_pkg::OP_SET_CUR || cmd.opcode == tcw_pkg::OP_READ) begin
            state_next = tcw_pkg::S_DIV;
          end else begin
            state_next = tcw_pkg::S_EXEC;
          end
        end
      end
      tcw_pkg::S_DIV: begin
        if (t_col < COLS_B) state_next = tcw_pkg::S_EXEC;
      end
      tcw_pkg::S_EXEC: begin
        wr_addr    = cell_addr;
        attr_wd    = theme_r;
        state_next = tcw_pkg::S_DONE;
        unique case (op_r)
          tcw_pkg::OP_PUT: begin
            char_we = !is_newline;
            attr_we = !is_newline && use_theme_r;
            char_wd = put_code;
            if (put_scroll) state_next = tcw_pkg::S_SCROLL;
          end
          tcw_pkg::OP_SET_CHAR: begin
            char_we = in_range;
            char_wd = code_r;
          end
          tcw_pkg::OP_SET_THEME: attr_we = in_range;
          tcw_pkg::OP_SET_ALL:   state_next = tcw_pkg::S_FILL;
          tcw_pkg::OP_CLEAR:     state_next = tcw_pkg::S_FILL;
          tcw_pkg::OP_READ: begin
            rd_en = in_range;
            if (in_range) state_next = tcw_pkg::S_READ;
          end
          default: ;
        endcase
      end
      tcw_pkg::S_READ: state_next = tcw_pkg::S_DONE;
      tcw_pkg::S_FILL: begin
        char_we = fill_char;
        attr_we = fill_attr;
        if (idx == LAST_CELL) state_next = tcw_pkg::S_DONE;
      end
      tcw_pkg::S_SCROLL: begin
        // Read the cell one row below while writing the previous read one cell behind
        rd_addr = idx + tcw_pkg::ADDR_W'(tcw_pkg::COLS);
        rd_en   = idx != SCROLL_END;
        wr_addr = idx - tcw_pkg::ADDR_W'(1);
        char_we = idx != '0;
        attr_we = idx != '0;
        char_wd = char_q;
        attr_wd = attr_q;
        if (idx == SCROLL_END) state_next = tcw_pkg::S_FILL;
      end
      tcw_pkg::S_DONE: begin
        if (rsp_free) state_next = tcw_pkg::S_IDLE;
      end
      default: state_next = tcw_pkg::S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (char_we) char_mem[wr_addr] <= char_wd;
    if (attr_we) attr_mem[wr_addr] <= attr_wd;
    if (rd_en) begin
      char_q <= char_mem[rd_addr];
      attr_q <= attr_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= tcw_pkg::S_INIT;
      idx          <= '0;
      cur_row      <= '0;
      cur_col      <= '0;
      global_theme <= tcw_pkg::THEME_DEFAULT;
      rsp_valid    <= 1'b0;
      fill_char    <= 1'b0;
      fill_attr    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == tcw_pkg::S_DONE && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        tcw_pkg::S_INIT: idx <= idx + tcw_pkg::ADDR_W'(1);
        tcw_pkg::S_IDLE: begin
          if (cmd.valid) begin
            op_r        <= cmd.opcode;
            code_r      <= cmd.char_code;
            use_theme_r <= cmd.use_theme;
            theme_r     <= cmd_theme;
            res_char    <= '0;
            res_attr    <= '0;
            if (cmd.opcode == tcw_pkg::OP_PUT) begin
              t_row <= tcw_pkg::TROW_W'(cur_row);
              t_col <= tcw_pkg::BYTE_W'(cur_col);
            end else begin
              t_row <= tcw_pkg::TROW_W'(cmd.row);
              t_col <= cmd.col;
            end
          end
        end
        tcw_pkg::S_DIV: begin
          // Fold an oversized column into the following rows
          if (t_col >= COLS_B) begin
            t_col <= t_col - COLS_B;
            t_row <= t_row + tcw_pkg::TROW_W'(1);
          end
        end
        tcw_pkg::S_EXEC: begin
          idx <= '0;
          unique case (op_r)
            tcw_pkg::OP_PUT: begin
              if (put_wrap) begin
                cur_col <= '0;
                if (!put_scroll) cur_row <= cur_row + tcw_pkg::ROW_W'(1);
              end else begin
                cur_col <= cur_col + tcw_pkg::COL_W'(1);
              end
            end
            tcw_pkg::OP_SET_ALL: begin
              global_theme <= theme_r;
              fill_char    <= 1'b0;
              fill_attr    <= 1'b1;
            end
            tcw_pkg::OP_CLEAR: begin
              cur_row   <= '0;
              cur_col   <= '0;
              fill_char <= 1'b1;
              fill_attr <= 1'b0;
            end
            tcw_pkg::OP_SET_CUR: begin
              if (in_range) begin
                cur_row <= t_row[tcw_pkg::ROW_W-1:0];
                cur_col <= t_col[tcw_pkg::COL_W-1:0];
              end
            end
            default: ;
          endcase
        end
        tcw_pkg::S_READ: begin
          res_char <= char_q;
          res_attr <= attr_q;
        end
        tcw_pkg::S_FILL: idx <= idx + tcw_pkg::ADDR_W'(1);
        tcw_pkg::S_SCROLL: begin
          // Hand over to the fill sweep of the last row, starting where the copy ended
          if (idx == SCROLL_END) begin
            fill_char <= 1'b1;
            fill_attr <= 1'b1;
          end else begin
            idx <= idx + tcw_pkg::ADDR_W'(1);
          end
        end
        tcw_pkg::S_DONE: begin
          if (rsp_free) begin
            rsp_col   <= tcw_pkg::CUR_COL_W'(cur_col);
            rsp_row   <= tcw_pkg::CUR_ROW_W'(cur_row);
            rsp_char  <= res_char;
            rsp_attr  <= res_attr;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cursor_bounds: assert property (@(posedge clk) disable iff (rst)
    cur_row <= LAST_ROW && cur_col <= LAST_COL)
    else $error("cursor left the grid");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> !cmd.ready)
    else $error("second command taken while one is in progress");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == tcw_pkg::S_IDLE |-> !char_we && !attr_we)
    else $error("memory written while idle");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == tcw_pkg::S_DONE))
    else $error("response raised outside the completion step");
`endif

endmodule
